// ===== rtl/core/dad_pkg.sv =====
`timescale 1ns / 1ps

package dad_pkg;

  localparam logic [3:0]  MonthsPerYear = 4'd12;
  localparam logic [3:0]  MonthFeb      = 4'd2;
  localparam logic [13:0] YearMax       = 14'h3FFF;
  // floor(y * Recip25 >> RecipShift) == floor(y / 25) for every 14-bit y
  localparam logic [12:0] Recip25       = 13'd5243;
  localparam int          RecipShift    = 17;
  localparam logic [4:0]  Cycle25       = 5'd25;

  typedef struct packed {
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [14:0] days_to_add;
  } in_t;

  typedef struct packed {
    logic [4:0]  end_day;
    logic [3:0]  end_month;
    logic [13:0] end_year;
  } out_t;

  typedef struct packed {
    logic load;      // capture the word, start the divide by 25
    logic calc_mod;  // form year mod 25
    logic init;      // form day of year plus count
    logic step;      // take off one month
  } cmd_t;

  typedef struct packed {
    logic walk_done;
  } status_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the months before this one, common year
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    unique case (month)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/dad_ctrl.sv =====
`timescale 1ns / 1ps

module dad_ctrl import dad_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    out_valid
);

  typedef enum logic [1:0] {ST_IDLE, ST_MOD, ST_INIT, ST_WALK} state_t;

  state_t state_r;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (start) state_r <= ST_MOD;
        ST_MOD:  state_r <= ST_INIT;
        ST_INIT: state_r <= ST_WALK;
        ST_WALK: begin
          if (status.walk_done) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == ST_IDLE) && start;
    cmd.calc_mod = (state_r == ST_MOD);
    cmd.init     = (state_r == ST_INIT);
    cmd.step     = (state_r == ST_WALK) && !status.walk_done;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/dad_datapath.sv =====
`timescale 1ns / 1ps

module dad_datapath import dad_pkg::*; (
  input  logic    clk,
  input  in_t     in_data,
  input  cmd_t    cmd,
  output status_t status,
  output out_t    out_data
);

  logic [4:0]  day_r;
  logic [3:0]  month_r;
  logic [13:0] year_r;
  logic [14:0] add_r;
  logic [9:0]  quot_r;
  logic [4:0]  mod25_r;
  logic [15:0] remain_r;
  logic [3:0]  m_r;

  logic [26:0] recip_prod;
  logic [13:0] quot_x25;
  logic [13:0] mod_diff;
  logic        leap;
  logic [4:0]  len_cur;
  logic [15:0] doy_sum;

  assign recip_prod = 27'(in_data.start_year) * 27'(Recip25);
  assign quot_x25   = 14'(quot_r) * 14'(Cycle25);
  assign mod_diff   = year_r - quot_x25;

  // divisible by 4, and not by 100 unless by 400 (400 = 16 * 25)
  assign leap    = (year_r[1:0] == 2'b00) && ((mod25_r != 5'd0) || (year_r[3:0] == 4'd0));
  assign len_cur = month_len(m_r, leap);

  assign doy_sum = 16'(day_r) + 16'(add_r) + 16'(days_before(month_r))
                 + 16'(leap && (month_r > MonthFeb));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day_r   <= (in_data.start_day == 5'd0) ? 5'd1 : in_data.start_day;
      month_r <= (in_data.start_month == 4'd0)        ? 4'd1 :
                 (in_data.start_month > MonthsPerYear) ? MonthsPerYear :
                                                         in_data.start_month;
      year_r  <= in_data.start_year;
      add_r   <= in_data.days_to_add;
      quot_r  <= recip_prod[RecipShift +: 10];
    end
    if (cmd.calc_mod) begin
      mod25_r <= mod_diff[4:0];
    end
    if (cmd.init) begin
      remain_r <= doy_sum;
      m_r      <= 4'd1;
    end
    if (cmd.step) begin
      remain_r <= remain_r - 16'(len_cur);
      if (m_r == MonthsPerYear) begin
        m_r    <= 4'd1;
        year_r <= year_r + 14'd1;
        // the year wraps to zero, which is a multiple of 25
        if (year_r == YearMax || mod25_r == Cycle25 - 5'd1) begin
          mod25_r <= 5'd0;
        end else begin
          mod25_r <= mod25_r + 5'd1;
        end
      end else begin
        m_r <= m_r + 4'd1;
      end
    end
  end

  assign status.walk_done = (remain_r <= 16'(len_cur));

  assign out_data.end_day   = remain_r[4:0];
  assign out_data.end_month = m_r;
  assign out_data.end_year  = year_r;

endmodule

// ===== rtl/core/date_add_days_core.sv =====
`timescale 1ns / 1ps
// Channel   Handshake               Word
// input     start, busy             in_data  (start_day, start_month, start_year, days_to_add)
// result    out_valid (strobe)      out_data (end_day, end_month, end_year)
//
// A word is taken when start is high and busy is low; busy then stays high
// while year mod 25 and the day of year are formed and N months are walked (up
// to about 1090, one month per cycle), and the result strobe follows in the next cycle.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// any word in flight. The result is shown for one cycle and cannot be stalled.

module date_add_days_core import dad_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  in_t  in_data,
  output logic busy,
  output logic out_valid,
  output out_t out_data
);

  cmd_t    cmd;
  status_t status;

  // Controller: idle -> year mod 25 -> day of year -> month walk -> strobe.
  dad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Datapath: holds the word, the running remainder, month and year.
  dad_datapath u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

  // A taken word makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // The result strobe lasts one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A result carries a real month and a nonzero day.
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.end_month >= 4'd1 && out_data.end_month <= MonthsPerYear
                   && out_data.end_day != 5'd0))
    else $error("result date out of range");

  // The strobe comes only at the end of a busy stretch.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe without a busy stretch");

endmodule

// ===== test/tb_date_add_days_core.sv =====
`timescale 1ns / 1ps

module tb_date_add_days_core;
  import dad_pkg::*;

  // Run shape: a short table of hand-picked dates, then random words.
  localparam int NumDirected = 22;
  localparam int TotalWords  = NumDirected + 520;
  // Hold no idle gaps for this stretch of words, so words go in back to back.
  localparam int BurstFirst  = 150;
  localparam int BurstLast   = 220;
  // After this word, stop sending until every pending date has come back.
  localparam int DrainAt     = 300;
  // A word walks at most about 1090 months; give the watchdog a wide margin.
  localparam int StallLimit  = 5000;
  localparam int DrainCycles = 1200;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  in_t  in_data;
  logic busy;
  logic out_valid;
  out_t out_data;

  // One row of the directed table: the word to send, and where the answer is
  // obvious, the date typed in by hand (typed = 1). Other rows use the
  // predictor. Layout is the packed order: in_t, typed, out_t.
  typedef struct packed {
    in_t  word;
    logic typed;
    out_t want;
  } dir_row_t;

  //                 day    mon    year        days        typed  day    mon    year
  dir_row_t directed_words [NumDirected] = '{
    // plain date, nothing added
    {5'd1,  4'd1,  14'd2024,  15'd0,     1'b1, 5'd1,  4'd1,  14'd2024},
    // year rollover on the last day of December
    {5'd31, 4'd12, 14'd2023,  15'd1,     1'b1, 5'd1,  4'd1,  14'd2024},
    // leap rules: divisible by 4, plain year, century, 400th year
    {5'd28, 4'd2,  14'd2024,  15'd1,     1'b1, 5'd29, 4'd2,  14'd2024},
    {5'd28, 4'd2,  14'd2023,  15'd1,     1'b1, 5'd1,  4'd3,  14'd2023},
    {5'd28, 4'd2,  14'd1900,  15'd1,     1'b1, 5'd1,  4'd3,  14'd1900},
    {5'd28, 4'd2,  14'd2000,  15'd1,     1'b1, 5'd29, 4'd2,  14'd2000},
    // month zero reads as January, month above 12 as December
    {5'd1,  4'd0,  14'd2023,  15'd0,     1'b1, 5'd1,  4'd1,  14'd2023},
    {5'd1,  4'd15, 14'd2023,  15'd0,     1'b1, 5'd1,  4'd12, 14'd2023},
    // day zero reads as day one
    {5'd0,  4'd5,  14'd2023,  15'd0,     1'b1, 5'd1,  4'd5,  14'd2023},
    // day past the end of its month rolls into the next months
    {5'd31, 4'd4,  14'd2023,  15'd0,     1'b1, 5'd1,  4'd5,  14'd2023},
    {5'd31, 4'd2,  14'd2023,  15'd0,     1'b1, 5'd3,  4'd3,  14'd2023},
    // year zero counts as a leap year
    {5'd28, 4'd2,  14'd0,     15'd1,     1'b1, 5'd29, 4'd2,  14'd0},
    // year counter wraps past its top value
    {5'd31, 4'd12, 14'd16383, 15'd1,     1'b1, 5'd1,  4'd1,  14'd0},
    // range ends of a well-formed date, and one whole year added
    {5'd1,  4'd1,  14'd1,     15'd0,     1'b1, 5'd1,  4'd1,  14'd1},
    {5'd31, 4'd12, 14'd9999,  15'd0,     1'b1, 5'd31, 4'd12, 14'd9999},
    {5'd1,  4'd1,  14'd2023,  15'd365,   1'b1, 5'd1,  4'd1,  14'd2024},
    // all zeros: day and month both clamp
    {5'd0,  4'd0,  14'd0,     15'd0,     1'b1, 5'd1,  4'd1,  14'd0},
    // largest counts, longest walks, then two mid-size counts
    {5'd1,  4'd1,  14'd1,     15'd32767, 1'b0, 23'd0},
    {5'd31, 4'd12, 14'd9999,  15'd32767, 1'b0, 23'd0},
    {5'd31, 4'd15, 14'd16383, 15'd32767, 1'b0, 23'd0},
    {5'd15, 4'd6,  14'd2024,  15'd1000,  1'b0, 23'd0},
    {5'd29, 4'd2,  14'd2024,  15'd1461,  1'b0, 23'd0}
  };

  // Dates still owed by the block, oldest first.
  out_t due_dates [$];

  int words_sent;
  int results_seen;
  int mismatch_count;
  int idle_cycles;

  date_add_days_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gregorian month length: every 4th year leaps, centuries skip unless
  // they also divide by 400.
  function automatic int unsigned month_days(input logic [3:0] month,
                                             input logic [13:0] year);
    logic        leap;
    int unsigned len;
    leap = (year % 400 == 0) || ((year % 100 != 0) && (year % 4 == 0));
    case (month)
      MonthFeb:                len = leap ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 30;
      default:                 len = 31;
    endcase
    return len;
  endfunction

  // Predict the resulting date: clamp month and day, form the day of year
  // plus the count, then peel off whole months starting from January.
  function automatic out_t date_after_days(input in_t w);
    logic [13:0] yr;
    logic [3:0]  mo;
    int unsigned remain;
    out_t        r;
    yr = w.start_year;
    mo = w.start_month;
    if (mo < 4'd1) mo = 4'd1;
    if (mo > MonthsPerYear) mo = MonthsPerYear;
    remain = (w.start_day == 5'd0) ? 1 : w.start_day;
    for (int m = 1; m < mo; m++) remain += month_days(m[3:0], yr);
    remain += w.days_to_add;
    mo = 4'd1;
    while (remain > month_days(mo, yr)) begin
      remain -= month_days(mo, yr);
      if (mo == MonthsPerYear) begin
        mo = 4'd1;
        yr = yr + 14'd1;   // 14-bit counter, wraps by itself
      end else begin
        mo = mo + 4'd1;
      end
    end
    r.end_day   = remain[4:0];
    r.end_month = mo;
    r.end_year  = yr;
    return r;
  endfunction

  // Mostly well-formed dates with short counts; some noise words that use
  // the full width of every field, and a few counts up to the maximum.
  function automatic in_t random_date_word();
    in_t w;
    int  pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      w.start_year  = 14'($urandom_range(1, 9999));
      w.start_month = 4'($urandom_range(1, 12));
      w.start_day   = 5'($urandom_range(1, month_days(w.start_month, w.start_year)));
    end else begin
      w.start_year  = 14'($urandom_range(0, 16383));
      w.start_month = 4'($urandom_range(0, 15));
      w.start_day   = 5'($urandom_range(0, 31));
    end
    pick = $urandom_range(0, 99);
    if (pick < 55)      w.days_to_add = 15'($urandom_range(0, 60));
    else if (pick < 85) w.days_to_add = 15'($urandom_range(0, 1000));
    else if (pick < 95) w.days_to_add = 15'($urandom_range(0, 8000));
    else                w.days_to_add = 15'($urandom_range(0, 32767));
    return w;
  endfunction

  // Idle gap after a word: mostly none or short, now and then long.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 150);
  endfunction

  // Raise start with the word and hold it until a rising edge finds busy low;
  // log the owed date at that same edge. Leave start high for the caller.
  task automatic issue_word(input in_t w, input out_t want);
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    due_dates.push_back(want);
    words_sent++;
  endtask

  // Check every strobed result against the oldest owed date.
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (due_dates.size() == 0) begin
        $display("%0t: result %0d/%0d/%0d with no date pending", $time,
                 out_data.end_day, out_data.end_month, out_data.end_year);
        mismatch_count++;
      end else begin
        want = due_dates.pop_front();
        if (out_data.end_day !== want.end_day) begin
          $display("%0t: end_day expected %0d, got %0d", $time,
                   want.end_day, out_data.end_day);
          mismatch_count++;
        end
        if (out_data.end_month !== want.end_month) begin
          $display("%0t: end_month expected %0d, got %0d", $time,
                   want.end_month, out_data.end_month);
          mismatch_count++;
        end
        if (out_data.end_year !== want.end_year) begin
          $display("%0t: end_year expected %0d, got %0d", $time,
                   want.end_year, out_data.end_year);
          mismatch_count++;
        end
      end
    end
  end

  // Drop the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, StallLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    in_t  w;
    out_t want;
    int   gap;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_data        = '0;
    words_sent     = 0;
    results_seen   = 0;
    mismatch_count = 0;
    idle_cycles    = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < TotalWords; i++) begin
      // Walk the directed table first, then switch to random words.
      if (i < NumDirected) begin
        w    = directed_words[i].word;
        want = directed_words[i].typed ? directed_words[i].want : date_after_days(w);
      end else begin
        w    = random_date_word();
        want = date_after_days(w);
      end
      issue_word(w, want);

      gap = (i >= BurstFirst && i < BurstLast) ? 0 : gap_len();
      // Lower start only when a gap or the drain pause follows; otherwise
      // keep it high so the next word goes in without a bubble.
      if (gap != 0 || i == DrainAt) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if (i == DrainAt) begin
        while (due_dates.size() != 0) @(posedge clk);
        @(posedge clk);
      end
    end
    start <= 1'b0;

    // Wait out the owed dates, then watch a while longer for strays.
    while (due_dates.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d date words (%0d from the directed table), checked %0d results",
             words_sent, NumDirected, results_seen);
    $display("Covered leap and century years, clamped fields, day overflow and year wrap");
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dad_pkg.sv
rtl/core/dad_ctrl.sv
rtl/core/dad_datapath.sv
rtl/core/date_add_days_core.sv
test/tb_date_add_days_core.sv
